// ===== rtl/ttgw_pkg.sv =====
// Shared types and character codes for the terminal text grid writer.
`timescale 1ns / 1ps

package ttgw_pkg;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_BS  = 8'h08;

  typedef enum logic [2:0] {
    OP_SKIP,
    OP_PRINT,
    OP_LF,
    OP_CR,
    OP_BS,
    OP_READ
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [31:0] top_line;
    logic [31:0] bottom_line;
    logic [6:0]  cursor_col;
    logic        in_escape;
    logic [31:0] printed_count;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [7:0]  data_byte;
    logic [5:0]  read_row;
    logic [6:0]  read_col;
    logic        in_escape;
    logic [31:0] printed_count;
  } cmd_t;

endpackage

// ===== rtl/ttgw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ttgw_ram #(
  parameter int Width = 8,
  parameter int Depth = 5490,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ttgw_front.sv =====
// Front end: accepts items, tracks escape state and byte count, classifies bytes.
`timescale 1ns / 1ps

module ttgw_front import ttgw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  logic        esc_q, esc_d;
  logic [31:0] total_q, total_d;
  op_e         op;
  logic        accept;

  assign in_ready_o  = en_i && cmd_ready_i;
  assign cmd_valid_o = in_valid_i && en_i;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    esc_d   = esc_q;
    total_d = total_q;
    op      = OP_SKIP;
    if (in_data_i.kind) begin
      op = OP_READ;
    end else if (esc_q) begin
      // drop everything up to and including the closing letter
      if (in_data_i.data_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
        esc_d = 1'b0;
      end
    end else begin
      total_d = total_q + 32'd1;
      case (in_data_i.data_byte)
        CH_ESC:  esc_d = 1'b1;
        CH_LF:   op = OP_LF;
        CH_CR:   op = OP_CR;
        CH_BS:   op = OP_BS;
        default: op = OP_PRINT;
      endcase
    end
  end

  always_comb begin
    cmd_o.op            = op;
    cmd_o.data_byte     = in_data_i.data_byte;
    cmd_o.read_row      = in_data_i.read_row;
    cmd_o.read_col      = in_data_i.read_col;
    cmd_o.in_escape     = esc_d;
    cmd_o.printed_count = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      total_q <= 32'd0;
    end else if (accept) begin
      esc_q   <= esc_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== rtl/ttgw_fifo.sv =====
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps

module ttgw_fifo import ttgw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/ttgw_back.sv =====
// Back end: grid memory, cursor and line counters, result register.
`timescale 1ns / 1ps

module ttgw_back import ttgw_pkg::*; #(
  parameter int ROWS = 45,
  parameter int COLS = 122
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  output logic      busy_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);

  localparam int Depth = ROWS * COLS;
  localparam int AddrW = $clog2(Depth);
  localparam int RowW  = $clog2(ROWS);
  localparam int ColW  = $clog2(COLS);
  localparam logic [RowW-1:0]  LastRow  = RowW'(ROWS - 1);
  localparam logic [ColW-1:0]  LastCol  = ColW'(COLS - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // The cell under the cursor always reads as zero; memory may still hold the
  // old byte there. It is zeroed when the cursor leaves without printing.
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;
  logic [31:0]      bottom_q, bottom_d, top_q, top_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             pop, advance, op_we, rd_en, in_range, at_cursor, use_mem;
  logic [7:0]       op_wdata;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             we;
  logic [7:0]       wdata, rdata;
  logic             out_valid_q, use_mem_q;
  out_item_t        out_q;

  assign busy_o      = clr_busy_q;
  assign cmd_ready_o = !clr_busy_q && (!out_valid_q || out_ready_i);
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    in_range  = (32'(cmd_i.read_row) < 32'(ROWS)) && (32'(cmd_i.read_col) < 32'(COLS));
    at_cursor = (32'(cmd_i.read_row) == 32'(row_q)) && (32'(cmd_i.read_col) == 32'(col_q));
    rd_addr   = AddrW'(32'(cmd_i.read_row) * 32'(COLS) + 32'(cmd_i.read_col));
  end

  always_comb begin
    bottom_d = bottom_q;
    top_d    = top_q;
    row_d    = row_q;
    base_d   = base_q;
    col_d    = col_q;
    advance  = 1'b0;
    op_we    = 1'b0;
    op_wdata = 8'd0;
    rd_en    = 1'b0;
    use_mem  = 1'b0;
    if (pop) begin
      case (cmd_i.op)
        OP_PRINT: begin
          op_we    = 1'b1;
          op_wdata = cmd_i.data_byte;
          if (col_q == LastCol) begin
            advance = 1'b1;
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
        OP_LF: begin
          op_we   = 1'b1;
          advance = 1'b1;
        end
        OP_CR: begin
          op_we = 1'b1;
          col_d = '0;
        end
        OP_BS: begin
          op_we = 1'b1;
          if (col_q != '0) begin
            col_d = col_q - ColW'(1);
          end
        end
        OP_READ: begin
          rd_en   = in_range;
          use_mem = in_range && !at_cursor;
        end
        default: ;
      endcase
    end
    if (advance) begin
      col_d    = '0;
      bottom_d = bottom_q + 32'd1;
      // scroll once more than ROWS lines are held
      if ((bottom_d - top_q) > 32'(ROWS)) begin
        top_d = top_q + 32'd1;
      end
      if (row_q == LastRow) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + RowW'(1);
        base_d = base_q + AddrW'(COLS);
      end
    end
  end

  assign we      = clr_busy_q || op_we;
  assign wr_addr = clr_busy_q ? clr_addr_q : base_q + AddrW'(col_q);
  assign wdata   = clr_busy_q ? 8'd0 : op_wdata;

  ttgw_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      bottom_q    <= 32'd0;
      top_q       <= 32'd0;
      row_q       <= '0;
      base_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      bottom_q <= bottom_d;
      top_q    <= top_d;
      row_q    <= row_d;
      base_q   <= base_d;
      col_q    <= col_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      use_mem_q           <= use_mem;
      out_q.read_char     <= 8'd0;
      out_q.top_line      <= top_d;
      out_q.bottom_line   <= bottom_d;
      out_q.cursor_col    <= 7'(32'(col_d));
      out_q.in_escape     <= cmd_i.in_escape;
      out_q.printed_count <= cmd_i.printed_count;
    end
  end

  // Read data stays put while the result waits: no new read issues until it moves.
  always_comb begin
    out_data_o           = out_q;
    out_data_o.read_char = use_mem_q ? rdata : 8'd0;
  end

  assign out_valid_o = out_valid_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop)
    else $error("item taken during grid clear");

  a_scroll_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bottom_q - top_q) <= 32'(ROWS))
    else $error("more lines held than the ring has rows");

  a_base_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) == 32'(row_q) * 32'(COLS))
    else $error("row base address out of step with ring row");

  a_cursor_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < 32'(COLS)) && (32'(row_q) < 32'(ROWS)))
    else $error("cursor outside the grid");

  a_newline_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == OP_LF) |=> bottom_q == $past(bottom_q) + 32'd1)
    else $error("newline did not advance the bottom line");

endmodule

// ===== rtl/terminal_text_grid_writer.sv =====
// Top level of the terminal text grid writer: front, queue and back.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-------------------------
//   input   | in_valid_i  | in_ready_o  | in_data_i  (in_item_t)
//   output  | out_valid_o | out_ready_i | out_data_o (out_item_t)
//
// One item per cycle sustained unless the grid clear or a stalled output holds
// the flow; each item leaves a result in the cycle after the back end takes it
// from the two-entry queue, as the grid memory read data is registered.
// After reset the grid memory is cleared one cell a cycle, all ROWS*COLS cells
// (5490 at the default size); no item is accepted until then.
// A stalled output holds the result register; the queue keeps taking items
// until it is full.
`timescale 1ns / 1ps

module terminal_text_grid_writer import ttgw_pkg::*; #(
  parameter int ROWS = 45,
  parameter int COLS = 122
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);

  logic busy;
  logic fe_valid, fe_ready;
  cmd_t fe_cmd;
  logic be_valid, be_ready;
  cmd_t be_cmd;

  ttgw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (!busy),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .cmd_valid_o(fe_valid),
    .cmd_o      (fe_cmd),
    .cmd_ready_i(fe_ready)
  );

  ttgw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fe_valid),
    .push_data_i (fe_cmd),
    .push_ready_o(fe_ready),
    .pop_valid_o (be_valid),
    .pop_data_o  (be_cmd),
    .pop_ready_i (be_ready)
  );

  ttgw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(be_valid),
    .cmd_i      (be_cmd),
    .cmd_ready_o(be_ready),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

endmodule
